FILE: sv/tob_pkg.sv
package tob_pkg;

    localparam int TILE_SIZE  = 256;
    localparam int MAX_EXTENT = 4096;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 8;
    localparam int COORD_W    = 12;
    localparam int ALPHA_W    = 16;

    // quotient bits resolved per divider stage
    localparam int DIV_STAGES = 4;
    localparam int STEP_BITS  = ALPHA_W / DIV_STAGES;

    // divider stages, then multiply / add for the top seam, then for the left seam
    localparam int LATENCY = DIV_STAGES + 4;

    localparam int TILE_MAX  = TILE_SIZE - 1;
    localparam int FIELD_MAX = (1 << COORD_W) - 1;
    localparam int DEST_MAX  = (MAX_EXTENT - 1 < FIELD_MAX) ? MAX_EXTENT - 1 : FIELD_MAX;

    localparam int PROD_W = SAMPLE_W + ALPHA_W + 2;
    localparam int ACC_W  = PROD_W + 1;
    localparam int HALF   = 1 << (ALPHA_W - 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [COORD_W-1:0]         coord_t;
    typedef logic [ALPHA_W-1:0]         alpha_t;

    typedef enum logic [1:0] {
        CFG_OVERLAP_TOP  = 2'd0,
        CFG_OVERLAP_LEFT = 2'd1,
        CFG_ORIGIN_ROW   = 2'd2,
        CFG_ORIGIN_COL   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        pos_t    local_row;
        pos_t    local_col;
        sample_t cur_red;
        sample_t cur_green;
        sample_t cur_blue;
        sample_t top_red;
        sample_t top_green;
        sample_t top_blue;
        sample_t side_red;
        sample_t side_green;
        sample_t side_blue;
    } pix_in_t;

    typedef struct packed {
        sample_t out_red;
        sample_t out_green;
        sample_t out_blue;
        coord_t  dest_row;
        coord_t  dest_col;
    } pix_out_t;

    typedef struct packed {
        logic use_top;
        logic use_left;
    } blend_ctl_t;

    typedef struct packed {
        pos_t   rem;
        pos_t   ovl;
        alpha_t quo;
    } div_state_t;

endpackage

FILE: sv/tob_div.sv
module tob_div (
    input  logic          clk,
    input  tob_pkg::pos_t pos,
    input  tob_pkg::pos_t ovl,
    output tob_pkg::alpha_t alpha
);
    import tob_pkg::*;

    div_state_t st_reg  [DIV_STAGES];
    div_state_t st_next [DIV_STAGES];

    // restoring division of pos * 2^16 by ovl; pos < ovl keeps the remainder in pos width
    always_comb
    begin
        div_state_t w;
        logic [POS_W:0] dbl;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                w.rem = pos;
                w.ovl = ovl;
                w.quo = '0;
            end
            else
            begin
                w = st_reg[s-1];
            end
            for (int b = 0; b < STEP_BITS; b++)
            begin
                dbl = {w.rem, 1'b0};
                if (dbl >= {1'b0, w.ovl})
                begin
                    w.rem = POS_W'(dbl - {1'b0, w.ovl});
                    w.quo = {w.quo[ALPHA_W-2:0], 1'b1};
                end
                else
                begin
                    w.rem = dbl[POS_W-1:0];
                    w.quo = {w.quo[ALPHA_W-2:0], 1'b0};
                end
            end
            st_next[s] = w;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign alpha = st_reg[DIV_STAGES-1].quo;

endmodule

FILE: sv/tob_lane.sv
module tob_lane (
    input  logic                clk,
    input  tob_pkg::sample_t    cur,
    input  tob_pkg::sample_t    top,
    input  tob_pkg::sample_t    side,
    input  tob_pkg::blend_ctl_t ctl,
    input  tob_pkg::alpha_t     a_top,
    input  tob_pkg::alpha_t     a_left,
    output tob_pkg::sample_t    blended
);
    import tob_pkg::*;

    // samples wait here while the dividers work out the weights
    sample_t    cur_reg  [DIV_STAGES];
    sample_t    top_reg  [DIV_STAGES];
    sample_t    side_reg [DIV_STAGES];
    blend_ctl_t ctl_reg  [DIV_STAGES];

    logic signed [PROD_W-1:0] prod1_reg, prod1_next;
    sample_t    nb1_reg, cur1_reg, side1_reg;
    blend_ctl_t ctl1_reg;
    alpha_t     aleft1_reg;

    sample_t    r1_reg, r1_next, side2_reg;
    blend_ctl_t ctl2_reg;
    alpha_t     aleft2_reg;

    logic signed [PROD_W-1:0] prod2_reg, prod2_next;
    sample_t    nb2_reg, r2_reg;
    logic       use_left_reg;

    sample_t    blended_reg, blended_next;

    logic signed [SAMPLE_W:0] diff1, diff2;
    logic signed [ACC_W-1:0]  acc1, acc2;

    localparam int L = DIV_STAGES - 1;

    // nb * (1 - a) + cur * a written as nb * 2^16 + (cur - nb) * a
    assign diff1      = (SAMPLE_W+1)'(cur_reg[L]) - (SAMPLE_W+1)'(top_reg[L]);
    assign prod1_next = PROD_W'(diff1) * PROD_W'($signed({1'b0, a_top}));

    assign acc1    = (ACC_W'(nb1_reg) <<< ALPHA_W) + ACC_W'(prod1_reg) + ACC_W'(HALF);
    assign r1_next = ctl1_reg.use_top ? sample_t'(acc1[ALPHA_W +: SAMPLE_W]) : cur1_reg;

    assign diff2      = (SAMPLE_W+1)'(r1_reg) - (SAMPLE_W+1)'(side2_reg);
    assign prod2_next = PROD_W'(diff2) * PROD_W'($signed({1'b0, aleft2_reg}));

    assign acc2         = (ACC_W'(nb2_reg) <<< ALPHA_W) + ACC_W'(prod2_reg) + ACC_W'(HALF);
    assign blended_next = use_left_reg ? sample_t'(acc2[ALPHA_W +: SAMPLE_W]) : r2_reg;

    always_ff @(posedge clk)
    begin
        cur_reg[0]  <= cur;
        top_reg[0]  <= top;
        side_reg[0] <= side;
        ctl_reg[0]  <= ctl;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            cur_reg[k]  <= cur_reg[k-1];
            top_reg[k]  <= top_reg[k-1];
            side_reg[k] <= side_reg[k-1];
            ctl_reg[k]  <= ctl_reg[k-1];
        end

        prod1_reg  <= prod1_next;
        nb1_reg    <= top_reg[L];
        cur1_reg   <= cur_reg[L];
        side1_reg  <= side_reg[L];
        ctl1_reg   <= ctl_reg[L];
        aleft1_reg <= a_left;

        r1_reg     <= r1_next;
        side2_reg  <= side1_reg;
        ctl2_reg   <= ctl1_reg;
        aleft2_reg <= aleft1_reg;

        prod2_reg    <= prod2_next;
        nb2_reg      <= side2_reg;
        r2_reg       <= r1_reg;
        use_left_reg <= ctl2_reg.use_left;

        blended_reg <= blended_next;
    end

    assign blended = blended_reg;

endmodule

FILE: sv/tile_overlap_blend.sv
// a word taken on start comes out on result_strobe, registered through the stages below
// throughput: one word per cycle, busy stays low; four-stage weight divider,
//   then a multiply and a round-and-add stage for each seam in every colour lane
// the receiver cannot stall: each result shows for one cycle only
// reset clears the in-flight valid bits and the tile registers; the data path
//   registers are left as they are
module tile_overlap_blend (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tob_pkg::pix_in_t  pixel,
    output logic              result_strobe,
    output tob_pkg::pix_out_t result,
    input  logic              cfg_we,
    input  tob_pkg::cfg_idx_t cfg_idx,
    input  tob_pkg::coord_t   cfg_data
);
    import tob_pkg::*;

    pos_t   overlap_top_reg, overlap_left_reg;
    coord_t origin_row_reg, origin_col_reg;

    logic [LATENCY-1:0] vld_reg, vld_next;
    coord_t drow_reg [LATENCY];
    coord_t dcol_reg [LATENCY];

    logic       accept;
    pos_t       row_c, col_c;
    blend_ctl_t ctl;
    alpha_t     a_top, a_left;
    logic [COORD_W:0] drow_sum, dcol_sum;
    coord_t     drow_c, dcol_c;
    sample_t    red, green, blue;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_top_reg  <= '0;
            overlap_left_reg <= '0;
            origin_row_reg   <= '0;
            origin_col_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_OVERLAP_TOP:  overlap_top_reg  <= cfg_data[POS_W-1:0];
                CFG_OVERLAP_LEFT: overlap_left_reg <= cfg_data[POS_W-1:0];
                CFG_ORIGIN_ROW:   origin_row_reg   <= cfg_data;
                CFG_ORIGIN_COL:   origin_col_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to the tile edge
    assign row_c = ((POS_W+2)'(pixel.local_row) > (POS_W+2)'(TILE_MAX)) ?
                   POS_W'(TILE_MAX) : pixel.local_row;
    assign col_c = ((POS_W+2)'(pixel.local_col) > (POS_W+2)'(TILE_MAX)) ?
                   POS_W'(TILE_MAX) : pixel.local_col;

    assign ctl.use_top  = (overlap_top_reg != '0) && (row_c < overlap_top_reg);
    assign ctl.use_left = (overlap_left_reg != '0) && (col_c < overlap_left_reg);

    assign drow_sum = {1'b0, origin_row_reg} + (COORD_W+1)'(row_c);
    assign dcol_sum = {1'b0, origin_col_reg} + (COORD_W+1)'(col_c);
    assign drow_c   = (drow_sum > (COORD_W+1)'(DEST_MAX)) ? COORD_W'(DEST_MAX)
                                                          : drow_sum[COORD_W-1:0];
    assign dcol_c   = (dcol_sum > (COORD_W+1)'(DEST_MAX)) ? COORD_W'(DEST_MAX)
                                                          : dcol_sum[COORD_W-1:0];

    tob_div u_div_top (
        .clk   (clk),
        .pos   (row_c),
        .ovl   (overlap_top_reg),
        .alpha (a_top)
    );

    tob_div u_div_left (
        .clk   (clk),
        .pos   (col_c),
        .ovl   (overlap_left_reg),
        .alpha (a_left)
    );

    tob_lane u_lane_red (
        .clk     (clk),
        .cur     (pixel.cur_red),
        .top     (pixel.top_red),
        .side    (pixel.side_red),
        .ctl     (ctl),
        .a_top   (a_top),
        .a_left  (a_left),
        .blended (red)
    );

    tob_lane u_lane_green (
        .clk     (clk),
        .cur     (pixel.cur_green),
        .top     (pixel.top_green),
        .side    (pixel.side_green),
        .ctl     (ctl),
        .a_top   (a_top),
        .a_left  (a_left),
        .blended (green)
    );

    tob_lane u_lane_blue (
        .clk     (clk),
        .cur     (pixel.cur_blue),
        .top     (pixel.top_blue),
        .side    (pixel.side_blue),
        .ctl     (ctl),
        .a_top   (a_top),
        .a_left  (a_left),
        .blended (blue)
    );

    assign vld_next = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drow_reg[0] <= drow_c;
        dcol_reg[0] <= dcol_c;
        for (int k = 1; k < LATENCY; k++)
        begin
            drow_reg[k] <= drow_reg[k-1];
            dcol_reg[k] <= dcol_reg[k-1];
        end
    end

    // merge the colour lanes with the coordinate line
    assign result_strobe    = vld_reg[LATENCY-1];
    assign result.out_red   = red;
    assign result.out_green = green;
    assign result.out_blue  = blue;
    assign result.dest_row  = drow_reg[LATENCY-1];
    assign result.dest_col  = dcol_reg[LATENCY-1];

    localparam int NUM_W = POS_W + ALPHA_W;

    a_strobe_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without a word taken");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && $past(accept && !ctl.use_top && !ctl.use_left, LATENCY)
        |-> result.out_red == $past(pixel.cur_red, LATENCY))
        else $error("unblended word altered");

    a_weight_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STAGES-1] && $past(ctl.use_top, DIV_STAGES)
        |-> (NUM_W'(a_top) * NUM_W'($past(overlap_top_reg, DIV_STAGES))
                 <= {$past(row_c, DIV_STAGES), ALPHA_W'(0)})
            && ({$past(row_c, DIV_STAGES), ALPHA_W'(0)}
                 - NUM_W'(a_top) * NUM_W'($past(overlap_top_reg, DIV_STAGES))
                 < NUM_W'($past(overlap_top_reg, DIV_STAGES))))
        else $error("top weight is not the floor quotient");

endmodule
